// ===== sv/blend_state_decoder_macros.svh =====
// assertion macros for the blend state decoder
`ifndef BLEND_STATE_DECODER_MACROS_SVH
`define BLEND_STATE_DECODER_MACROS_SVH

// clocked assertion, quiet while reset is held
`define BSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication into the next cycle
`define BSD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/bsd_pkg.sv =====
// types, codes and decode functions of the blend state decoder
package bsd_pkg;

  localparam int unsigned FactorW = 5;
  localparam int unsigned OpW     = 3;
  localparam int unsigned RgbSelW = 3;
  localparam int unsigned ASelW   = 2;
  localparam int unsigned ConstW  = 32;

  // api factor codes
  localparam logic [FactorW-1:0] F_ZERO            = 5'd1;
  localparam logic [FactorW-1:0] F_ONE             = 5'd2;
  localparam logic [FactorW-1:0] F_SRCCOLOR        = 5'd3;
  localparam logic [FactorW-1:0] F_INVSRCCOLOR     = 5'd4;
  localparam logic [FactorW-1:0] F_SRCALPHA        = 5'd5;
  localparam logic [FactorW-1:0] F_INVSRCALPHA     = 5'd6;
  localparam logic [FactorW-1:0] F_DESTALPHA       = 5'd7;
  localparam logic [FactorW-1:0] F_INVDESTALPHA    = 5'd8;
  localparam logic [FactorW-1:0] F_DESTCOLOR       = 5'd9;
  localparam logic [FactorW-1:0] F_INVDESTCOLOR    = 5'd10;
  localparam logic [FactorW-1:0] F_SRCALPHASAT     = 5'd11;
  localparam logic [FactorW-1:0] F_BOTHSRCALPHA    = 5'd12;
  localparam logic [FactorW-1:0] F_BOTHINVSRCALPHA = 5'd13;
  localparam logic [FactorW-1:0] F_BLENDFACTOR     = 5'd14;
  localparam logic [FactorW-1:0] F_INVBLENDFACTOR  = 5'd15;

  // api operation codes
  localparam logic [OpW-1:0] API_ADD    = 3'd1;
  localparam logic [OpW-1:0] API_SUB    = 3'd2;
  localparam logic [OpW-1:0] API_REVSUB = 3'd3;
  localparam logic [OpW-1:0] API_MIN    = 3'd4;
  localparam logic [OpW-1:0] API_MAX    = 3'd5;

  // raster operation codes
  localparam logic [OpW-1:0] OP_ADD    = 3'd0;
  localparam logic [OpW-1:0] OP_SUB    = 3'd1;
  localparam logic [OpW-1:0] OP_REVSUB = 3'd2;
  localparam logic [OpW-1:0] OP_MIN    = 3'd3;
  localparam logic [OpW-1:0] OP_MAX    = 3'd4;

  // color selectors
  localparam logic [RgbSelW-1:0] RS_ZERO     = 3'd0;
  localparam logic [RgbSelW-1:0] RS_SRCCOLOR = 3'd1;
  localparam logic [RgbSelW-1:0] RS_SRCALPHA = 3'd2;
  localparam logic [RgbSelW-1:0] RS_SRCASAT  = 3'd3;
  localparam logic [RgbSelW-1:0] RS_DSTALPHA = 3'd4;
  localparam logic [RgbSelW-1:0] RS_DSTCOLOR = 3'd5;
  localparam logic [RgbSelW-1:0] RS_CONST    = 3'd6;

  // alpha selectors
  localparam logic [ASelW-1:0] AS_ZERO     = 2'd0;
  localparam logic [ASelW-1:0] AS_SRCALPHA = 2'd1;
  localparam logic [ASelW-1:0] AS_DSTALPHA = 2'd2;
  localparam logic [ASelW-1:0] AS_CONST    = 2'd3;

  typedef struct packed {
    logic                 blend_enable;
    logic [FactorW-1:0]   src_color_factor;
    logic [FactorW-1:0]   dst_color_factor;
    logic [OpW-1:0]       color_op;
    logic [FactorW-1:0]   src_alpha_factor;
    logic [FactorW-1:0]   dst_alpha_factor;
    logic [OpW-1:0]       alpha_op;
    logic [ConstW-1:0]    constant_argb;
  } req_t;

  typedef struct packed {
    logic [RgbSelW-1:0] src_rgb_select;
    logic               src_rgb_invert;
    logic [RgbSelW-1:0] dst_rgb_select;
    logic               dst_rgb_invert;
    logic [OpW-1:0]     rgb_operation;
    logic [ASelW-1:0]   src_a_select;
    logic               src_a_invert;
    logic [ASelW-1:0]   dst_a_select;
    logic               dst_a_invert;
    logic [OpW-1:0]     a_operation;
    logic               load_source;
    logic               load_dest;
  } res_t;

  typedef struct packed {
    logic [RgbSelW-1:0] sel;
    logic               inv;
  } rgb_fac_t;

  typedef struct packed {
    logic [ASelW-1:0] sel;
    logic             inv;
  } a_fac_t;

  function automatic rgb_fac_t map_rgb(input logic [FactorW-1:0] code, input logic is_dest);
    rgb_fac_t f;
    f = '{sel: RS_ZERO, inv: 1'b0};
    case (code)
      F_ONE:             f = '{sel: RS_ZERO,     inv: 1'b1};
      F_SRCCOLOR:        f = '{sel: RS_SRCCOLOR, inv: 1'b0};
      F_INVSRCCOLOR:     f = '{sel: RS_SRCCOLOR, inv: 1'b1};
      F_SRCALPHA:        f = '{sel: RS_SRCALPHA, inv: 1'b0};
      F_INVSRCALPHA:     f = '{sel: RS_SRCALPHA, inv: 1'b1};
      F_DESTALPHA:       f = '{sel: RS_DSTALPHA, inv: 1'b0};
      F_INVDESTALPHA:    f = '{sel: RS_DSTALPHA, inv: 1'b1};
      F_DESTCOLOR:       f = '{sel: RS_DSTCOLOR, inv: 1'b0};
      F_INVDESTCOLOR:    f = '{sel: RS_DSTCOLOR, inv: 1'b1};
      F_SRCALPHASAT:     f = '{sel: RS_SRCASAT,  inv: 1'b0};
      F_BOTHSRCALPHA:    f = '{sel: RS_SRCALPHA, inv: is_dest};
      F_BOTHINVSRCALPHA: f = '{sel: RS_SRCALPHA, inv: ~is_dest};
      F_BLENDFACTOR:     f = '{sel: RS_CONST,    inv: 1'b0};
      F_INVBLENDFACTOR:  f = '{sel: RS_CONST,    inv: 1'b1};
      default:           f = '{sel: RS_ZERO,     inv: 1'b0};
    endcase
    return f;
  endfunction

  // color sources fold onto alpha sources, srcalphasat acts as one
  function automatic a_fac_t map_a(input logic [FactorW-1:0] code, input logic is_dest);
    a_fac_t f;
    f = '{sel: AS_ZERO, inv: 1'b0};
    case (code)
      F_ONE:             f = '{sel: AS_ZERO,     inv: 1'b1};
      F_SRCCOLOR:        f = '{sel: AS_SRCALPHA, inv: 1'b0};
      F_INVSRCCOLOR:     f = '{sel: AS_SRCALPHA, inv: 1'b1};
      F_SRCALPHA:        f = '{sel: AS_SRCALPHA, inv: 1'b0};
      F_INVSRCALPHA:     f = '{sel: AS_SRCALPHA, inv: 1'b1};
      F_DESTALPHA:       f = '{sel: AS_DSTALPHA, inv: 1'b0};
      F_INVDESTALPHA:    f = '{sel: AS_DSTALPHA, inv: 1'b1};
      F_DESTCOLOR:       f = '{sel: AS_DSTALPHA, inv: 1'b0};
      F_INVDESTCOLOR:    f = '{sel: AS_DSTALPHA, inv: 1'b1};
      F_SRCALPHASAT:     f = '{sel: AS_ZERO,     inv: 1'b1};
      F_BOTHSRCALPHA:    f = '{sel: AS_SRCALPHA, inv: is_dest};
      F_BOTHINVSRCALPHA: f = '{sel: AS_SRCALPHA, inv: ~is_dest};
      F_BLENDFACTOR:     f = '{sel: AS_CONST,    inv: 1'b0};
      F_INVBLENDFACTOR:  f = '{sel: AS_CONST,    inv: 1'b1};
      default:           f = '{sel: AS_ZERO,     inv: 1'b0};
    endcase
    return f;
  endfunction

  function automatic logic [OpW-1:0] map_op(input logic [OpW-1:0] code);
    logic [OpW-1:0] op;
    case (code)
      API_ADD:    op = OP_ADD;
      API_SUB:    op = OP_SUB;
      API_REVSUB: op = OP_REVSUB;
      API_MIN:    op = OP_MIN;
      API_MAX:    op = OP_MAX;
      default:    op = OP_ADD;
    endcase
    return op;
  endfunction

  function automatic res_t decode(input req_t q);
    res_t     r;
    rgb_fac_t sr;
    rgb_fac_t dr;
    a_fac_t   sa;
    a_fac_t   da;
    logic     color_zero;
    logic     alpha_zero;
    logic     ls;
    logic     ld;
    sr = map_rgb(q.src_color_factor, 1'b0);
    dr = map_rgb(q.dst_color_factor, 1'b1);
    sa = map_a(q.src_alpha_factor, 1'b0);
    da = map_a(q.dst_alpha_factor, 1'b1);
    color_zero = (q.constant_argb[23:0] == 24'd0);
    alpha_zero = (q.constant_argb[31:24] == 8'd0);
    ls = 1'b0;
    ld = 1'b0;
    r.rgb_operation = map_op(q.color_op);
    r.a_operation   = map_op(q.alpha_op);

    case (sr.sel)
      RS_ZERO:                              ls = sr.inv;
      RS_SRCCOLOR, RS_SRCALPHA:             ls = 1'b1;
      RS_SRCASAT, RS_DSTALPHA, RS_DSTCOLOR: begin
        ls = 1'b1;
        ld = 1'b1;
      end
      default:                              ls = ~color_zero;
    endcase
    case (dr.sel)
      RS_ZERO:                              ld = ld | dr.inv;
      RS_SRCCOLOR, RS_SRCALPHA, RS_SRCASAT: begin
        ls = 1'b1;
        ld = 1'b1;
      end
      RS_DSTALPHA, RS_DSTCOLOR:             ld = 1'b1;
      default:                              ld = ld | ~color_zero;
    endcase
    case (sa.sel)
      AS_ZERO:     ls = ls | sa.inv;
      AS_SRCALPHA: ls = 1'b1;
      AS_DSTALPHA: begin
        ls = 1'b1;
        ld = 1'b1;
      end
      default:     ls = ls | ~alpha_zero;
    endcase
    case (da.sel)
      AS_ZERO:     ld = ld | da.inv;
      AS_SRCALPHA: begin
        ls = 1'b1;
        ld = 1'b1;
      end
      AS_DSTALPHA: ld = 1'b1;
      default:     ld = ld | ~alpha_zero;
    endcase

    // min and max read both sides whatever the factors
    if (r.rgb_operation == OP_MIN || r.rgb_operation == OP_MAX ||
        r.a_operation == OP_MIN || r.a_operation == OP_MAX) begin
      ls = 1'b1;
      ld = 1'b1;
    end

    r.src_rgb_select = sr.sel;
    r.src_rgb_invert = sr.inv;
    r.dst_rgb_select = dr.sel;
    r.dst_rgb_invert = dr.inv;
    r.src_a_select   = sa.sel;
    r.src_a_invert   = sa.inv;
    r.dst_a_select   = da.sel;
    r.dst_a_invert   = da.inv;
    r.load_source    = ls;
    r.load_dest      = ld;

    // blending off: source passes through unchanged
    if (!q.blend_enable) begin
      r = '{src_rgb_select: RS_ZERO, src_rgb_invert: 1'b1,
            dst_rgb_select: RS_ZERO, dst_rgb_invert: 1'b0,
            rgb_operation: OP_ADD,
            src_a_select: AS_ZERO, src_a_invert: 1'b1,
            dst_a_select: AS_ZERO, dst_a_invert: 1'b0,
            a_operation: OP_ADD,
            load_source: 1'b1, load_dest: 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== sv/blend_state_decoder.sv =====
// blend state decoder: api blend state in, raster blend control word out
//
//  channel  | prefix | direction | contents
//  request  | in_    | in        | enable, four factor codes, two op codes, constant
//  result   | out_   | out       | selectors, inverts, operations, load flags
//
// one request per cycle sustained while out_stall is low; path: input register, then result register
// the decode is a single pass of table lookups and small or-terms between the registers
// rst_n is synchronous and clears both valid bits; payload registers are not reset
// a stalled result holds in the result register while one more request waits in the
// input register; in_stall rises only when both are full and out_stall is high
module blend_state_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_blend_enable,
  input  logic [bsd_pkg::FactorW-1:0]   in_src_color_factor,
  input  logic [bsd_pkg::FactorW-1:0]   in_dst_color_factor,
  input  logic [bsd_pkg::OpW-1:0]       in_color_op,
  input  logic [bsd_pkg::FactorW-1:0]   in_src_alpha_factor,
  input  logic [bsd_pkg::FactorW-1:0]   in_dst_alpha_factor,
  input  logic [bsd_pkg::OpW-1:0]       in_alpha_op,
  input  logic [bsd_pkg::ConstW-1:0]    in_constant_argb,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsd_pkg::RgbSelW-1:0]   out_src_rgb_select,
  output logic                          out_src_rgb_invert,
  output logic [bsd_pkg::RgbSelW-1:0]   out_dst_rgb_select,
  output logic                          out_dst_rgb_invert,
  output logic [bsd_pkg::OpW-1:0]       out_rgb_operation,
  output logic [bsd_pkg::ASelW-1:0]     out_src_a_select,
  output logic                          out_src_a_invert,
  output logic [bsd_pkg::ASelW-1:0]     out_dst_a_select,
  output logic                          out_dst_a_invert,
  output logic [bsd_pkg::OpW-1:0]       out_a_operation,
  output logic                          out_load_source,
  output logic                          out_load_dest
);
  import bsd_pkg::*;

  `include "blend_state_decoder_macros.svh"

  logic in_valid_r;
  logic in_valid_nxt;
  req_t req_r;
  logic out_valid_r;
  logic out_valid_nxt;
  res_t res_r;
  res_t res_nxt;
  logic out_free;
  logic in_take;
  logic res_load;
  logic minmax_ok;
  logic pair_stalled;

  assign out_free = !out_valid_r || !out_stall;
  assign res_load = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign res_nxt = decode(req_r);

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !out_free);
    out_valid_nxt = res_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= '{blend_enable: in_blend_enable,
                 src_color_factor: in_src_color_factor,
                 dst_color_factor: in_dst_color_factor,
                 color_op: in_color_op,
                 src_alpha_factor: in_src_alpha_factor,
                 dst_alpha_factor: in_dst_alpha_factor,
                 alpha_op: in_alpha_op,
                 constant_argb: in_constant_argb};
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_src_rgb_select = res_r.src_rgb_select;
  assign out_src_rgb_invert = res_r.src_rgb_invert;
  assign out_dst_rgb_select = res_r.dst_rgb_select;
  assign out_dst_rgb_invert = res_r.dst_rgb_invert;
  assign out_rgb_operation  = res_r.rgb_operation;
  assign out_src_a_select   = res_r.src_a_select;
  assign out_src_a_invert   = res_r.src_a_invert;
  assign out_dst_a_select   = res_r.dst_a_select;
  assign out_dst_a_invert   = res_r.dst_a_invert;
  assign out_a_operation    = res_r.a_operation;
  assign out_load_source    = res_r.load_source;
  assign out_load_dest      = res_r.load_dest;

  assign minmax_ok = !(res_r.rgb_operation == OP_MIN || res_r.rgb_operation == OP_MAX ||
                       res_r.a_operation == OP_MIN || res_r.a_operation == OP_MAX) ||
                     (res_r.load_source && res_r.load_dest);
  assign pair_stalled = in_valid_r && out_valid_r && out_stall;

  // min or max on either channel must read both sides
  `BSD_ASSERT(a_minmax_loads, !out_valid_r || minmax_ok, "min/max result without both load flags")
  // an accepted request lands in the input register
  `BSD_ASSERT_NEXT(a_take_lands, in_take, in_valid_r, "accepted request lost")
  // a waiting request survives a stalled result
  `BSD_ASSERT_NEXT(a_hold_req, pair_stalled, in_valid_r && out_valid_r, "request dropped under stall")

endmodule
